// ===== rtl/wpmv_pkg.sv =====
// Shared types and constants for the PCM16 mono volume stream block.
// No dependencies; imported by the parser, the scaler and the top level.

package wpmv_pkg;

    typedef enum logic [2:0] {
        KIND_SAMPLE    = 3'd0,
        KIND_HDR_OK    = 3'd1,
        KIND_BAD_MAGIC = 3'd2,
        KIND_BAD_BITS  = 3'd3,
        KIND_BAD_CHAN  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_ERROR  = 2'd2
    } phase_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] sample;
        logic [31:0]        rate;
    } result_t;

    // Configuration register indexes (word address bits [3:2]).
    localparam logic [1:0] REG_VOLUME  = 2'd0;
    localparam logic [1:0] REG_FLOOR   = 2'd1;
    localparam logic [1:0] REG_CEILING = 2'd2;

    localparam logic [7:0] VOLUME_RESET  = 8'd50;
    localparam logic [7:0] FLOOR_RESET   = 8'd0;
    localparam logic [7:0] CEILING_RESET = 8'd100;

    // Last header byte index, header tags with byte 0 in the low bits.
    localparam logic [5:0]  HDR_LAST    = 6'd43;
    localparam logic [31:0] TAG_RIFF    = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE    = 32'h4556_4157;
    localparam logic [15:0] BITS_PCM16  = 16'd16;

    // Division by 100 as multiplication by ceil(2^30 / 100); exact for
    // magnitudes below 2^23, which covers 32768 * 255.
    localparam logic [23:0] RECIP_100   = 24'd10737419;

endpackage

// ===== rtl/wav_pcm16_mono_volume_stream.sv =====
// Top level of the PCM16 mono volume stream block: configuration registers,
// header parser and volume scaler. Depends on wpmv_pkg, wpmv_parse, wpmv_scale.
// Path: a result's last byte loads the parser register; the result then passes the gain
// multiply stage and the divide/saturate output register, each of which holds one item.
// Throughput: one file byte per cycle while in_ready is high; the stages advance
// independently, and out_ready held low backs them up until in_ready drops.
// Reset: parser starts on a new header, volume 50, floor 0, ceiling 100, no result held.

module wav_pcm16_mono_volume_stream (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         file_byte,
    input  logic               file_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         kind,
    output logic signed [15:0] mono_sample,
    output logic [31:0]        rate_hz
);
    import wpmv_pkg::*;

    logic [7:0] volume_reg, volume_next;
    logic [7:0] floor_reg, floor_next;
    logic [7:0] ceiling_reg, ceiling_next;
    logic       cfg_write;
    logic [7:0] raised;
    logic [7:0] gain;

    logic       res_valid;
    logic       res_ready;
    result_t    res;
    result_t    out_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        volume_next  = volume_reg;
        floor_next   = floor_reg;
        ceiling_next = ceiling_reg;
        if (cfg_write)
        begin
            case (paddr[3:2])
                REG_VOLUME:  volume_next  = pwdata[7:0];
                REG_FLOOR:   floor_next   = pwdata[7:0];
                REG_CEILING: ceiling_next = pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_VOLUME:  prdata = {24'd0, volume_reg};
            REG_FLOOR:   prdata = {24'd0, floor_reg};
            REG_CEILING: prdata = {24'd0, ceiling_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg  <= VOLUME_RESET;
            floor_reg   <= FLOOR_RESET;
            ceiling_reg <= CEILING_RESET;
        end
        else
        begin
            volume_reg  <= volume_next;
            floor_reg   <= floor_next;
            ceiling_reg <= ceiling_next;
        end
    end

    // The ceiling is applied last, so it wins when the floor lies above it.
    assign raised = (volume_reg < floor_reg) ? floor_reg : volume_reg;
    assign gain   = (raised > ceiling_reg) ? ceiling_reg : raised;

    wpmv_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .file_byte  (file_byte),
        .file_start (file_start),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    wpmv_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain      (gain),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    assign kind        = out_item.kind;
    assign mono_sample = out_item.sample;
    assign rate_hz     = out_item.rate;

endmodule

// ===== rtl/wpmv_parse.sv =====
// Header parser and sample framer for the PCM16 mono volume stream block.
// Depends on wpmv_pkg; feeds one result register per completed item.

module wpmv_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        file_byte,
    input  logic              file_start,
    output logic              res_valid,
    input  logic              res_ready,
    output wpmv_pkg::result_t res
);
    import wpmv_pkg::*;

    logic        in_fire;

    phase_t      phase_reg, phase_next, cur_phase;
    logic [5:0]  pos_reg, pos_next, cur_pos;
    logic        tags_reg, tags_next, cur_tags;
    logic [15:0] chan_reg, chan_next, cur_chan;
    logic [31:0] rate_reg, rate_next, cur_rate;
    logic [15:0] bits_reg, bits_next, cur_bits;
    logic [7:0]  low_reg, low_next, cur_low;
    logic [15:0] left_reg, left_next, cur_left;
    logic [1:0]  frame_reg, frame_next, cur_frame;

    logic        s1_valid_reg, s1_valid_next;
    result_t     s1_reg, s1_next;
    logic        load;

    logic [15:0] word;
    logic [16:0] pair_sum;
    logic [16:0] pair_adj;
    kind_t       verdict;

    assign in_fire  = in_valid && in_ready;
    assign in_ready = !s1_valid_reg || res_ready;

    // A byte flagged as a file start sees the freshly restarted state.
    always_comb
    begin
        if (file_start)
        begin
            cur_phase = PH_HEADER;
            cur_pos   = '0;
            cur_tags  = 1'b1;
            cur_chan  = '0;
            cur_rate  = '0;
            cur_bits  = '0;
            cur_low   = '0;
            cur_left  = '0;
            cur_frame = '0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_pos   = pos_reg;
            cur_tags  = tags_reg;
            cur_chan  = chan_reg;
            cur_rate  = rate_reg;
            cur_bits  = bits_reg;
            cur_low   = low_reg;
            cur_left  = left_reg;
            cur_frame = frame_reg;
        end
    end

    assign word     = {file_byte, cur_low};
    assign pair_sum = {cur_left[15], cur_left} + {word[15], word};
    // Adding one to a negative sum makes the halving truncate toward zero.
    assign pair_adj = pair_sum + {16'd0, pair_sum[16]};

    always_comb
    begin
        if (!cur_tags)
            verdict = KIND_BAD_MAGIC;
        else if (cur_bits != BITS_PCM16)
            verdict = KIND_BAD_BITS;
        else if (cur_chan != 16'd1 && cur_chan != 16'd2)
            verdict = KIND_BAD_CHAN;
        else
            verdict = KIND_HDR_OK;
    end

    // Next state of the parser.
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        tags_next  = tags_reg;
        chan_next  = chan_reg;
        rate_next  = rate_reg;
        bits_next  = bits_reg;
        low_next   = low_reg;
        left_next  = left_reg;
        frame_next = frame_reg;
        if (in_fire)
        begin
            phase_next = cur_phase;
            pos_next   = cur_pos;
            tags_next  = cur_tags;
            chan_next  = cur_chan;
            rate_next  = cur_rate;
            bits_next  = cur_bits;
            low_next   = cur_low;
            left_next  = cur_left;
            frame_next = cur_frame;
            case (cur_phase)
                PH_HEADER:
                begin
                    case (cur_pos) inside
                        [6'd0:6'd3]:
                            if (file_byte != TAG_RIFF[{cur_pos[1:0], 3'b000} +: 8])
                                tags_next = 1'b0;
                        [6'd8:6'd11]:
                            if (file_byte != TAG_WAVE[{cur_pos[1:0], 3'b000} +: 8])
                                tags_next = 1'b0;
                        6'd22, 6'd23:
                            chan_next = cur_chan | ({8'd0, file_byte} << {cur_pos[0], 3'b000});
                        [6'd24:6'd27]:
                            rate_next = cur_rate
                                      | ({24'd0, file_byte} << {cur_pos[1:0], 3'b000});
                        6'd34, 6'd35:
                            bits_next = cur_bits | ({8'd0, file_byte} << {cur_pos[0], 3'b000});
                        default:
                        begin
                        end
                    endcase
                    if (cur_pos == HDR_LAST)
                    begin
                        pos_next   = '0;
                        frame_next = '0;
                        phase_next = (verdict == KIND_HDR_OK) ? PH_DATA : PH_ERROR;
                    end
                    else
                    begin
                        pos_next = cur_pos + 6'd1;
                    end
                end
                PH_DATA:
                begin
                    if (!cur_frame[0])
                    begin
                        low_next   = file_byte;
                        frame_next = cur_frame + 2'd1;
                    end
                    else if (cur_chan == 16'd1)
                    begin
                        frame_next = '0;
                    end
                    else if (cur_frame == 2'd1)
                    begin
                        left_next  = word;
                        frame_next = 2'd2;
                    end
                    else
                    begin
                        frame_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result produced by the accepted byte, if any.
    always_comb
    begin
        load           = 1'b0;
        s1_next        = s1_reg;
        if (in_fire)
        begin
            case (cur_phase)
                PH_HEADER:
                begin
                    if (cur_pos == HDR_LAST)
                    begin
                        load           = 1'b1;
                        s1_next.kind   = verdict;
                        s1_next.sample = '0;
                        s1_next.rate   = (verdict == KIND_HDR_OK) ? cur_rate : 32'd0;
                    end
                end
                PH_DATA:
                begin
                    if (cur_frame[0] && (cur_chan == 16'd1 || cur_frame == 2'd3))
                    begin
                        load           = 1'b1;
                        s1_next.kind   = KIND_SAMPLE;
                        s1_next.sample = (cur_chan == 16'd1) ? word : pair_adj[16:1];
                        s1_next.rate   = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (load)
            s1_valid_next = 1'b1;
        else if (res_ready)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            tags_reg     <= 1'b1;
            chan_reg     <= '0;
            rate_reg     <= '0;
            bits_reg     <= '0;
            low_reg      <= '0;
            left_reg     <= '0;
            frame_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            tags_reg     <= tags_next;
            chan_reg     <= chan_next;
            rate_reg     <= rate_next;
            bits_reg     <= bits_next;
            low_reg      <= low_next;
            left_reg     <= left_next;
            frame_reg    <= frame_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    assign res_valid = s1_valid_reg;
    assign res       = s1_reg;

    a_pos_only_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_HEADER |-> pos_reg == 6'd0)
        else $error("header byte index left nonzero outside the header");

    a_mono_frame: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA && chan_reg == 16'd1 |-> !frame_reg[1])
        else $error("mono stream entered the second half of a stereo frame");

    a_no_result_when_ignoring: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !file_start && phase_reg == PH_ERROR |=> !s1_valid_reg || $stable(s1_reg))
        else $error("a byte after a header error produced a result");

endmodule

// ===== rtl/wpmv_scale.sv =====
// Volume scaling pipeline: gain multiply, divide by 100 and saturation.
// Depends on wpmv_pkg; holds the result register that drives the output.

module wpmv_scale (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        gain,
    input  logic              res_valid,
    output logic              res_ready,
    input  wpmv_pkg::result_t res,
    output logic              out_valid,
    input  logic              out_ready,
    output wpmv_pkg::result_t out_item
);
    import wpmv_pkg::*;

    logic               s2_valid_reg, s2_valid_next;
    kind_t              s2_kind_reg;
    logic signed [24:0] s2_prod_reg;
    logic [31:0]        s2_rate_reg;
    logic               s2_ready;

    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;

    logic               neg;
    logic [24:0]        mag_wide;
    logic [22:0]        mag;
    logic [46:0]        recip_prod;
    logic [16:0]        quot;
    logic [16:0]        quot_neg;
    logic [15:0]        scaled;

    assign s2_ready  = !out_valid_reg || out_ready;
    assign res_ready = !s2_valid_reg || s2_ready;

    always_comb
    begin
        if (res_valid && res_ready)
            s2_valid_next = 1'b1;
        else if (s2_ready)
            s2_valid_next = 1'b0;
        else
            s2_valid_next = s2_valid_reg;

        if (s2_valid_reg && s2_ready)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Divide the magnitude, then restore the sign and clamp to 16 bits.
    assign neg        = s2_prod_reg[24];
    assign mag_wide   = neg ? 25'(-s2_prod_reg) : 25'(s2_prod_reg);
    assign mag        = mag_wide[22:0];
    assign recip_prod = 47'(mag) * 47'(RECIP_100);
    assign quot       = recip_prod[46:30];
    assign quot_neg   = 17'd0 - quot;

    always_comb
    begin
        if (neg)
            scaled = (quot > 17'd32768) ? 16'h8000 : quot_neg[15:0];
        else
            scaled = (quot > 17'd32767) ? 16'h7FFF : quot[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            s2_kind_reg <= res.kind;
            s2_prod_reg <= 25'(res.sample) * 25'($signed({1'b0, gain}));
            s2_rate_reg <= res.rate;
        end
        if (s2_valid_reg && s2_ready)
        begin
            out_reg.kind   <= s2_kind_reg;
            out_reg.sample <= scaled;
            out_reg.rate   <= s2_rate_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_status_has_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind != KIND_SAMPLE |-> out_reg.sample == 16'sd0)
        else $error("status result carries a nonzero sample");

    a_rate_only_on_header_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind != KIND_HDR_OK |-> out_reg.rate == 32'd0)
        else $error("rate reported on a result other than header ok");

    a_product_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> mag_wide[24:23] == 2'b00)
        else $error("gain product exceeds the divider's exact range");

endmodule
